@@ hw/rtl/alpn_sel_pkg.sv @@
// types, name tables and outcome codes for the alpn protocol selector
// no dependencies; every other file imports this package
package alpn_sel_pkg;

	typedef enum logic [1:0] {
		OUTCOME_SELECTED = 2'd0,
		OUTCOME_NO_ACK   = 2'd1,
		OUTCOME_FATAL    = 2'd2
	} outcome_t;

	localparam logic PROTO_H2     = 1'b0;
	localparam logic PROTO_HTTP11 = 1'b1;

	localparam int H2_LEN     = 2;
	localparam int HTTP11_LEN = 8;

	localparam logic [3:0] H2_LEN_W     = 4'(H2_LEN);
	localparam logic [3:0] HTTP11_LEN_W = 4'(HTTP11_LEN);
	localparam logic [3:0] NO_LEN_W     = 4'd0;

	localparam logic [7:0] NAME_H2 [H2_LEN] = '{8'h68, 8'h32};
	localparam logic [7:0] NAME_HTTP11 [HTTP11_LEN] = '{
		8'h68, 8'h74, 8'h74, 8'h70, 8'h2F, 8'h31, 8'h2E, 8'h31
	};

	typedef struct packed {
		logic [7:0] list_byte;
		logic       has_byte;
		logic       end_of_list;
	} in_word_t;

	typedef struct packed {
		outcome_t   outcome;
		logic       chosen_protocol;
		logic [3:0] chosen_length;
	} out_word_t;

endpackage

@@ hw/rtl/alpn_sel_in_if.sv @@
// valid/ready channel carrying one list word into the selector
// depends on alpn_sel_pkg
interface alpn_sel_in_if;
	import alpn_sel_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/alpn_sel_out_if.sv @@
// valid/ready channel carrying one selection result out of the selector
// depends on alpn_sel_pkg
interface alpn_sel_out_if;
	import alpn_sel_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/alpn_sel_scan.sv @@
// list scanner: entry parsing, on-the-fly name compare and final decision
// depends on alpn_sel_pkg
module alpn_sel_scan (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  alpn_sel_pkg::in_word_t  word,
	output alpn_sel_pkg::out_word_t result
);
	import alpn_sel_pkg::*;

	logic       in_name_q, in_name_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [3:0] name_pos_q, name_pos_d;
	logic       match_h2_q, match_h2_d;
	logic       match_http11_q, match_http11_d;
	logic       found_h2_q, found_h2_d;
	logic       found_http11_q, found_http11_d;
	logic       stopped_q, stopped_d;
	logic       any_seen_q, any_seen_d;

	logic       h2_ok, http11_ok;

	assign h2_ok = (name_pos_q < 4'(H2_LEN)) &&
		(NAME_H2[name_pos_q[0]] == word.list_byte);
	assign http11_ok = (name_pos_q < 4'(HTTP11_LEN)) &&
		(NAME_HTTP11[name_pos_q[2:0]] == word.list_byte);

	always_comb begin
		in_name_d      = in_name_q;
		bytes_left_d   = bytes_left_q;
		name_pos_d     = name_pos_q;
		match_h2_d     = match_h2_q;
		match_http11_d = match_http11_q;
		found_h2_d     = found_h2_q;
		found_http11_d = found_http11_q;
		stopped_d      = stopped_q;
		any_seen_d     = any_seen_q;

		if (step && word.has_byte) begin
			any_seen_d = 1'b1;
			if (!stopped_q) begin
				if (!in_name_q) begin
					if (word.list_byte == 8'd0) begin
						stopped_d = 1'b1;
					end else begin
						in_name_d      = 1'b1;
						bytes_left_d   = word.list_byte;
						name_pos_d     = 4'd0;
						match_h2_d     = (word.list_byte == 8'(H2_LEN));
						match_http11_d = (word.list_byte == 8'(HTTP11_LEN));
					end
				end else begin
					match_h2_d     = match_h2_q && h2_ok;
					match_http11_d = match_http11_q && http11_ok;
					// saturate once past the longest name
					if (name_pos_q < 4'(HTTP11_LEN)) begin
						name_pos_d = name_pos_q + 4'd1;
					end
					bytes_left_d = bytes_left_q - 8'd1;
					if (bytes_left_q == 8'd1) begin
						in_name_d      = 1'b0;
						found_h2_d     = found_h2_q || match_h2_d;
						found_http11_d = found_http11_q || match_http11_d;
						match_h2_d     = 1'b0;
						match_http11_d = 1'b0;
					end
				end
			end
		end

		priority if (!any_seen_d) begin
			result = '{OUTCOME_NO_ACK, PROTO_H2, NO_LEN_W};
		end else if (found_h2_d) begin
			result = '{OUTCOME_SELECTED, PROTO_H2, H2_LEN_W};
		end else if (found_http11_d) begin
			result = '{OUTCOME_SELECTED, PROTO_HTTP11, HTTP11_LEN_W};
		end else begin
			result = '{OUTCOME_FATAL, PROTO_H2, NO_LEN_W};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_name_q      <= 1'b0;
			bytes_left_q   <= 8'd0;
			name_pos_q     <= 4'd0;
			match_h2_q     <= 1'b0;
			match_http11_q <= 1'b0;
			found_h2_q     <= 1'b0;
			found_http11_q <= 1'b0;
			stopped_q      <= 1'b0;
			any_seen_q     <= 1'b0;
		end else if (step && word.end_of_list) begin
			in_name_q      <= 1'b0;
			bytes_left_q   <= 8'd0;
			name_pos_q     <= 4'd0;
			match_h2_q     <= 1'b0;
			match_http11_q <= 1'b0;
			found_h2_q     <= 1'b0;
			found_http11_q <= 1'b0;
			stopped_q      <= 1'b0;
			any_seen_q     <= 1'b0;
		end else begin
			in_name_q      <= in_name_d;
			bytes_left_q   <= bytes_left_d;
			name_pos_q     <= name_pos_d;
			match_h2_q     <= match_h2_d;
			match_http11_q <= match_http11_d;
			found_h2_q     <= found_h2_d;
			found_http11_q <= found_http11_d;
			stopped_q      <= stopped_d;
			any_seen_q     <= any_seen_d;
		end
	end

	a_open_entry_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		in_name_q |-> (bytes_left_q != 8'd0))
		else $error("open entry with no bytes left");

	a_match_only_in_name: assert property (@(posedge clk) disable iff (!arst_n)
		!in_name_q |-> (!match_h2_q && !match_http11_q))
		else $error("match flag set outside an entry");

	a_stop_closes_entry: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !in_name_q)
		else $error("scan stopped inside an entry");

	a_found_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(found_h2_q || found_http11_q || stopped_q || in_name_q) |-> any_seen_q)
		else $error("scan state without any byte seen");

endmodule

@@ hw/rtl/alpn_protocol_selector.sv @@
// top level of the alpn protocol selector: input register, scanner, result register
// depends on alpn_sel_pkg, alpn_sel_in_if, alpn_sel_out_if, alpn_sel_scan
//
//   channel   dir   word                                      words per list
//   list      in    list_byte, has_byte, end_of_list          any number
//   verdict   out   outcome, chosen_protocol, chosen_length    one, on end_of_list
//
// one word per cycle unless a held verdict stalls; the verdict is registered
// the scanner works on the registered word combinationally, no iteration
// arst_n clears the scan state and both valid flags
// a held verdict only stalls a later end_of_list word; other words keep flowing
module alpn_protocol_selector (
	input logic          clk,
	input logic          arst_n,
	alpn_sel_in_if.sink  list,
	alpn_sel_out_if.source verdict
);
	import alpn_sel_pkg::*;

	logic      valid_s1;
	in_word_t  word_s1;
	logic      consume;
	out_word_t result;
	logic      out_valid_q;
	out_word_t out_word_q;

	assign consume = valid_s1 &&
		(!word_s1.end_of_list || !out_valid_q || verdict.ready);
	assign list.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (list.ready) begin
			valid_s1 <= list.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (list.ready && list.valid) begin
			word_s1 <= list.payload;
		end
	end

	alpn_sel_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.word   (word_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && word_s1.end_of_list) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && word_s1.end_of_list) begin
			out_word_q <= result;
		end
	end

	assign verdict.valid   = out_valid_q;
	assign verdict.payload = out_word_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !verdict.ready) |-> !(consume && word_s1.end_of_list))
		else $error("verdict overwritten while held");

	a_consume_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		consume |-> valid_s1)
		else $error("scanner stepped without a word");

	a_verdict_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(consume && word_s1.end_of_list))
		else $error("verdict without a last word");

endmodule

@@ sim/tb.sv @@
// testbench for alpn_protocol_selector: drives client protocol lists word by word and
// checks every verdict against a scan model of its own, with random gaps and stalls
// depends on alpn_sel_pkg, alpn_sel_in_if, alpn_sel_out_if and the selector rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import alpn_sel_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 400;

	typedef enum int {
		ENT_H2,
		ENT_HTTP11,
		ENT_NEAR,
		ENT_LONGER,
		ENT_SHORTER,
		ENT_RANDOM,
		ENT_MAX
	} entry_kind_t;

	logic clk;
	logic arst_n;

	alpn_sel_in_if  list_ch ();
	alpn_sel_out_if verdict_ch ();

	alpn_protocol_selector uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.list    (list_ch),
		.verdict (verdict_ch)
	);

	// scan model state
	logic       scan_in_name;
	logic [7:0] scan_bytes_left;
	logic [7:0] scan_name_pos;
	logic       scan_match_h2;
	logic       scan_match_http11;
	logic       scan_found_h2;
	logic       scan_found_http11;
	logic       scan_stopped;
	logic       scan_seen;

	out_word_t  pending_verdicts [$];
	logic [7:0] list_bytes [$];

	int         mismatches;
	int         verdicts_seen;
	int         items_sent;
	int         cycle_count;
	int         burst_left;
	bit         gaps_on;
	bit         rx_stall;
	int         hold_req;
	int         hold_left;
	logic [7:0] rx_pattern;
	logic [2:0] rx_phase;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("error at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int name_len(input bit http);
		return http ? HTTP11_LEN : H2_LEN;
	endfunction

	function automatic logic [7:0] name_byte(input bit http, input int idx);
		if (http)
			return NAME_HTTP11[idx];
		return NAME_H2[idx];
	endfunction

	task automatic clear_scan();
		scan_in_name = 1'b0;
		scan_bytes_left = '0;
		scan_name_pos = '0;
		scan_match_h2 = 1'b0;
		scan_match_http11 = 1'b0;
		scan_found_h2 = 1'b0;
		scan_found_http11 = 1'b0;
		scan_stopped = 1'b0;
		scan_seen = 1'b0;
	endtask

	task automatic scan_byte(input logic [7:0] b);
		scan_seen = 1'b1;
		if (scan_stopped)
			return;
		if (!scan_in_name) begin
			if (b == 8'd0) begin
				scan_stopped = 1'b1;
				return;
			end
			scan_in_name = 1'b1;
			scan_bytes_left = b;
			scan_name_pos = '0;
			scan_match_h2 = (b == 8'(H2_LEN));
			scan_match_http11 = (b == 8'(HTTP11_LEN));
			return;
		end
		if (scan_match_h2) begin
			if (scan_name_pos >= H2_LEN)
				scan_match_h2 = 1'b0;
			else if (NAME_H2[scan_name_pos] != b)
				scan_match_h2 = 1'b0;
		end
		if (scan_match_http11) begin
			if (scan_name_pos >= HTTP11_LEN)
				scan_match_http11 = 1'b0;
			else if (NAME_HTTP11[scan_name_pos] != b)
				scan_match_http11 = 1'b0;
		end
		if (scan_name_pos != 8'hFF)
			scan_name_pos++;
		if (scan_bytes_left != 8'd0)
			scan_bytes_left--;
		if (scan_bytes_left == 8'd0) begin
			scan_in_name = 1'b0;
			if (scan_match_h2)
				scan_found_h2 = 1'b1;
			if (scan_match_http11)
				scan_found_http11 = 1'b1;
			scan_match_h2 = 1'b0;
			scan_match_http11 = 1'b0;
		end
	endtask

	// updates the scan on an accepted word and queues the verdict it closes
	task automatic track_word(input in_word_t w);
		out_word_t v;
		if (w.has_byte)
			scan_byte(w.list_byte);
		if (!w.end_of_list)
			return;
		v.outcome = OUTCOME_FATAL;
		v.chosen_protocol = PROTO_H2;
		v.chosen_length = NO_LEN_W;
		if (!scan_seen)
			v.outcome = OUTCOME_NO_ACK;
		else if (scan_found_h2) begin
			v.outcome = OUTCOME_SELECTED;
			v.chosen_length = H2_LEN_W;
		end else if (scan_found_http11) begin
			v.outcome = OUTCOME_SELECTED;
			v.chosen_protocol = PROTO_HTTP11;
			v.chosen_length = HTTP11_LEN_W;
		end
		pending_verdicts.push_back(v);
		clear_scan();
	endtask

	task automatic send_word(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				list_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		list_ch.valid <= 1'b1;
		list_ch.payload <= w;
		do
			@(posedge clk);
		while (list_ch.ready !== 1'b1);
		if (w.has_byte || w.end_of_list)
			items_sent++;
		track_word(w);
	endtask

	task automatic send_fields(input logic [7:0] b, input logic has, input logic last);
		in_word_t w;
		w.list_byte = b;
		w.has_byte = has;
		w.end_of_list = last;
		send_word(w);
	endtask

	// sends list_bytes, optionally closed by a word with no byte, with idle words mixed in
	task automatic send_list(input bit sep_end, input int idle_pct);
		int i;
		for (i = 0; i < list_bytes.size(); i++) begin
			if ($urandom_range(0, 99) < idle_pct)
				send_fields(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_fields(list_bytes[i], 1'b1, !sep_end && i == list_bytes.size() - 1);
		end
		if (sep_end || list_bytes.size() == 0)
			send_fields(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic add_entry(input entry_kind_t kind);
		int len;
		int pos;
		int i;
		bit http;
		http = 1'($urandom_range(0, 1));
		case (kind)
			ENT_H2, ENT_HTTP11: begin
				http = (kind == ENT_HTTP11);
				len = name_len(http);
				list_bytes.push_back(8'(len));
				for (i = 0; i < len; i++)
					list_bytes.push_back(name_byte(http, i));
			end
			ENT_NEAR: begin
				len = name_len(http);
				pos = $urandom_range(0, len - 1);
				list_bytes.push_back(8'(len));
				for (i = 0; i < len; i++)
					list_bytes.push_back(i == pos ?
						name_byte(http, i) ^ (8'd1 << $urandom_range(0, 7)) :
						name_byte(http, i));
			end
			ENT_LONGER: begin
				len = name_len(http) + $urandom_range(1, 3);
				list_bytes.push_back(8'(len));
				for (i = 0; i < len; i++)
					list_bytes.push_back(i < name_len(http) ?
						name_byte(http, i) : 8'($urandom_range(0, 255)));
			end
			ENT_SHORTER: begin
				len = $urandom_range(1, name_len(http) - 1);
				list_bytes.push_back(8'(len));
				for (i = 0; i < len; i++)
					list_bytes.push_back(name_byte(http, i));
			end
			ENT_RANDOM, ENT_MAX: begin
				len = (kind == ENT_MAX) ? 255 : $urandom_range(1, 12);
				list_bytes.push_back(8'(len));
				for (i = 0; i < len; i++)
					list_bytes.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	function automatic entry_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 18)
			return ENT_H2;
		if (r < 40)
			return ENT_HTTP11;
		if (r < 58)
			return ENT_NEAR;
		if (r < 70)
			return ENT_LONGER;
		if (r < 82)
			return ENT_SHORTER;
		if (r < 98)
			return ENT_RANDOM;
		return ENT_MAX;
	endfunction

	task automatic send_wellformed_list();
		int n;
		int r;
		int i;
		int len;
		int cnt;
		list_bytes.delete();
		n = $urandom_range(0, 4);
		for (i = 0; i < n; i++)
			add_entry(pick_kind());
		r = $urandom_range(0, 99);
		if (r < 12) begin
			// zero length stops the scan, trailing bytes ignored
			list_bytes.push_back(8'd0);
			cnt = $urandom_range(0, 6);
			for (i = 0; i < cnt; i++)
				list_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (r < 24) begin
			// entry cut off by the end of the list
			len = $urandom_range(0, 1) ? HTTP11_LEN : $urandom_range(2, 20);
			cnt = $urandom_range(0, len - 1);
			list_bytes.push_back(8'(len));
			for (i = 0; i < cnt; i++)
				list_bytes.push_back(len == HTTP11_LEN ?
					name_byte(1'b1, i) : 8'($urandom_range(0, 255)));
		end
		send_list($urandom_range(0, 9) == 0, 8);
	endtask

	task automatic send_noise_list();
		int n;
		int i;
		n = $urandom_range(1, 10);
		for (i = 0; i < n; i++)
			send_fields(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) != 0), i == n - 1);
	endtask

	task automatic test_empty_and_idle();
		send_fields(8'hFF, 1'b0, 1'b1);
		send_fields(8'h00, 1'b0, 1'b0);
		list_bytes = '{8'd2, NAME_H2[0], NAME_H2[1]};
		send_list(1'b1, 0);
	endtask

	task automatic test_selection_and_stop();
		list_bytes.delete();
		add_entry(ENT_HTTP11);
		list_bytes.push_back(8'd0);
		add_entry(ENT_H2);
		send_list(1'b0, 0);
	endtask

	task automatic test_cutoff_and_mismatch();
		list_bytes = '{8'd2, NAME_H2[0], 8'h33, 8'd255, NAME_H2[0]};
		send_list(1'b0, 0);
	endtask

	task automatic test_random_lists();
		int target;
		target = items_sent + 1100;
		while (items_sent < target) begin
			gaps_on = ($urandom_range(0, 2) != 0);
			rx_stall = ($urandom_range(0, 3) != 0);
			send_wellformed_list();
		end
	endtask

	task automatic test_noise_lists();
		int target;
		target = items_sent + 250;
		while (items_sent < target) begin
			gaps_on = ($urandom_range(0, 1) != 0);
			rx_stall = ($urandom_range(0, 1) != 0);
			send_noise_list();
		end
	endtask

	// receiver holds off while short lists keep coming, so the input stalls
	task automatic test_backpressure();
		int target;
		gaps_on = 1'b0;
		rx_stall = 1'b0;
		hold_req = HOLD_CYCLES;
		target = items_sent + 250;
		while (items_sent < target) begin
			list_bytes.delete();
			add_entry($urandom_range(0, 1) ? ENT_H2 : ENT_NEAR);
			send_list(1'b0, 0);
		end
	endtask

	// receiver stall pattern
	initial begin
		verdict_ch.ready = 1'b0;
		rx_phase = '0;
		rx_pattern = 8'hFF;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				verdict_ch.ready <= 1'b0;
			end else if (!rx_stall)
				verdict_ch.ready <= 1'b1;
			else begin
				if (rx_phase == 3'd0)
					rx_pattern = 8'($urandom_range(1, 255));
				verdict_ch.ready <= rx_pattern[rx_phase];
				rx_phase++;
			end
		end
	end

	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		if (arst_n === 1'b1 && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
			got = verdict_ch.payload;
			verdicts_seen++;
			if (pending_verdicts.size() == 0)
				report_mismatch($sformatf("verdict %0d arrived with none pending",
					verdicts_seen));
			else begin
				want = pending_verdicts.pop_front();
				if (got.outcome !== want.outcome)
					report_mismatch($sformatf("verdict %0d outcome %0d, want %0d",
						verdicts_seen, got.outcome, want.outcome));
				if (got.chosen_protocol !== want.chosen_protocol)
					report_mismatch($sformatf("verdict %0d protocol %0d, want %0d",
						verdicts_seen, got.chosen_protocol, want.chosen_protocol));
				if (got.chosen_length !== want.chosen_length)
					report_mismatch($sformatf("verdict %0d length %0d, want %0d",
						verdicts_seen, got.chosen_length, want.chosen_length));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		list_ch.valid = 1'b0;
		list_ch.payload = '0;
		mismatches = 0;
		verdicts_seen = 0;
		items_sent = 0;
		cycle_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		rx_stall = 1'b1;
		hold_req = 0;
		clear_scan();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_and_idle();
		test_selection_and_stop();
		test_cutoff_and_mismatch();
		test_random_lists();
		test_backpressure();
		test_noise_lists();

		list_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0)
			report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
